FILE: design/cdid_pkg.sv
package cdid_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_DUMP       = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // decoded request as it sits in the queue
    typedef struct packed {
        logic                     is_push;
        logic                     push_front;
        logic                     is_clear;
        logic                     is_dump;
        logic signed [WORD_W-1:0] value;
    } cmd_t;

    // head of the request queue as seen by the execution side
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } qhead_t;

endpackage

FILE: design/circular_deque_insert_dump_core.sv
// circular deque of DEPTH signed 32-bit words with push back, push front,
// clear and dump requests
// request channel: req_valid/req_ready carry operation and value; requests
// go into a two-entry queue, so req_ready drops only when that queue is full
// response channel: rsp_valid/rsp_ready carry status, data_valid, element
// and last; every request gives at least one response, the final one with
// last set
// push and clear give one response, loaded into the response register when
// popped from the request queue; back to back they complete one per cycle
// while rsp_ready stays high; a dump of a nonempty ring walks from head to
// tail, each element through S_READ (the registered ring read) and S_EMIT
// (loading the response register)
// a dump of an empty ring gives one response with empty status
// a stalled rsp_ready holds the response register; the execution side waits
// and the request queue keeps taking requests until it fills
// reset empties the request queue and the ring (head, tail at 0); the ring
// words themselves are not cleared
module circular_deque_insert_dump_core #(
    parameter int DEPTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [1:0]          operation,
    input  logic signed [31:0]  value,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [1:0]          status,
    output logic                data_valid,
    output logic signed [31:0]  element,
    output logic                last
);
    import cdid_pkg::*;

    qhead_t q_head;
    logic   q_pop;

    cdid_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .operation (operation),
        .value     (value),
        .q_head    (q_head),
        .q_pop     (q_pop)
    );

    cdid_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .status     (status),
        .data_valid (data_valid),
        .element    (element),
        .last       (last)
    );

`ifndef NO_ASSERTIONS
    // execution side only takes a request that is there
    a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head.valid)
        else $error("request queue popped while empty");

    // dumped words always carry ok status
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && data_valid) |-> (status == ST_OK))
        else $error("dump element with non-ok status");

    // single-response requests always close with last
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !data_valid) |-> last)
        else $error("status response without last");

    // a popped push or clear always produces a response
    a_pop_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_head.cmd.is_dump) |=> rsp_valid)
        else $error("push or clear gave no response");
`endif

endmodule

FILE: design/cdid_front.sv
module cdid_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [1:0]                    operation,
    input  logic signed [31:0]            value,
    output cdid_pkg::qhead_t              q_head,
    input  logic                          q_pop
);
    import cdid_pkg::*;

    localparam int QD = 2;

    cmd_t       entry_reg [QD];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       dec;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        dec = '0;
        dec.value = value;
        unique case (op_t'(operation))
            OP_PUSH_BACK:  dec.is_push = 1'b1;
            OP_PUSH_FRONT:
            begin
                dec.is_push    = 1'b1;
                dec.push_front = 1'b1;
            end
            OP_CLEAR:      dec.is_clear = 1'b1;
            OP_DUMP:       dec.is_dump = 1'b1;
            default:       dec.is_dump = 1'b1;
        endcase
    end

    assign req_ready    = (count_reg != 2'(QD));
    assign do_push      = req_valid && req_ready;
    assign do_pop       = q_pop && (count_reg != 2'd0);
    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (do_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

FILE: design/cdid_back.sv
module cdid_back #(
    parameter int DEPTH = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cdid_pkg::qhead_t     q_head,
    output logic                 q_pop,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [1:0]           status,
    output logic                 data_valid,
    output logic signed [31:0]   element,
    output logic                 last
);
    import cdid_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] i);
        return (i >= LAST_IDX) ? '0 : i + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] i);
        return (i == '0) ? LAST_IDX : i - PTR_W'(1);
    endfunction

    logic signed [WORD_W-1:0] ring_mem [DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic               empty_reg, empty_next;
    logic [PTR_W-1:0]   walk_reg, walk_next;
    logic [PTR_W-1:0]   cnt_reg, cnt_next;

    logic               rsp_valid_reg, rsp_valid_next;
    logic [1:0]         status_reg, status_next;
    logic               dv_reg, dv_next;
    logic signed [WORD_W-1:0] elem_reg, elem_next;
    logic               last_reg, last_next;

    logic               we;
    logic [PTR_W-1:0]   wr_addr;
    logic               out_free;
    logic               full;
    logic               fin;

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign full     = !empty_reg && (step_up(tail_reg) == head_reg);
    assign fin      = (walk_reg == tail_reg) || (cnt_reg == LAST_IDX);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        walk_next      = walk_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        dv_next        = dv_reg;
        elem_next      = elem_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        we             = 1'b0;
        wr_addr        = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_head.valid && out_free)
                begin
                    q_pop          = 1'b1;
                    rsp_valid_next = 1'b1;
                    status_next    = ST_OK;
                    dv_next        = 1'b0;
                    elem_next      = '0;
                    last_next      = 1'b1;
                    if (q_head.cmd.is_push)
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (empty_reg)
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b0;
                            we         = 1'b1;
                            wr_addr    = '0;
                        end
                        else if (!q_head.cmd.push_front)
                        begin
                            tail_next = step_up(tail_reg);
                            we        = 1'b1;
                            wr_addr   = step_up(tail_reg);
                        end
                        else
                        begin
                            head_next = step_down(head_reg);
                            we        = 1'b1;
                            wr_addr   = step_down(head_reg);
                        end
                    end
                    else if (q_head.cmd.is_clear)
                    begin
                        empty_next = 1'b1;
                        head_next  = '0;
                        tail_next  = '0;
                    end
                    else if (empty_reg)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        // nonempty dump: walk from head, one element per visit
                        rsp_valid_next = 1'b0;
                        walk_next      = head_reg;
                        cnt_next       = '0;
                        state_next     = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = ST_OK;
                    dv_next        = 1'b1;
                    elem_next      = rd_data_reg;
                    last_next      = fin;
                    if (fin)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        walk_next  = step_up(walk_reg);
                        cnt_next   = cnt_reg + PTR_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            walk_reg      <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            walk_reg      <= walk_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        dv_reg     <= dv_next;
        elem_reg   <= elem_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ring_mem[wr_addr] <= q_head.cmd.value;
        end
        rd_data_reg <= ring_mem[walk_reg];
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign data_valid = dv_reg;
    assign element    = elem_reg;
    assign last       = last_reg;

endmodule
